@@ src/bfpa_pkg.sv @@
// Package for the best-fit partition allocator: item types, sizes, codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package bfpa_pkg;
    localparam int MaxEntries = 16;
    localparam int SizeBits   = 20;
    localparam int IdxBits    = $clog2(MaxEntries);
    localparam int CntBits    = $clog2(MaxEntries + 1);

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_COMPACT = 2'd2;
    localparam logic [1:0] REQ_LIST    = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [7:0]          proc_id;
        logic [SizeBits-1:0] req_size;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [SizeBits-1:0] start_addr;
        logic [SizeBits-1:0] end_addr;
        logic [7:0]          owner;
        logic                is_free;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic                free;
        logic [7:0]          owner;
        logic [SizeBits-1:0] size;
    } entry_t;
endpackage

@@ src/bfpa_table.sv @@
// Partition table storage: one write port, one read port, registered read.
// Depends on bfpa_pkg.
`timescale 1ns / 1ps
module bfpa_table (
    input  logic                    clk,
    input  logic                    we,
    input  logic [bfpa_pkg::IdxBits-1:0] waddr,
    input  bfpa_pkg::entry_t        wdata,
    input  logic [bfpa_pkg::IdxBits-1:0] raddr,
    output bfpa_pkg::entry_t        rdata
);
    import bfpa_pkg::*;
    entry_t mem [MaxEntries];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/best_fit_partition_allocator_core.sv @@
// Top level of the best-fit partition allocator: sequencer and shared datapath.
// Depends on bfpa_pkg and bfpa_table.
`timescale 1ns / 1ps
// Usage:
//   in_valid/in_stall carries one request item (type, process, size). An item
//   is taken when in_valid is high and in_stall low; in_stall stays high while
//   the item is worked on. Each item gives one result item on out_valid/
//   out_stall, except a listing, which gives one per table entry and a tail
//   line, the final one flagged with last.
//   cfg_valid/cfg_ready writes total_size; the write empties the table. It is
//   taken only when the block is idle, no result waits and no item is offered.
//   Walk: in a search, release or compact the sequencer walks the table one
//   entry per cycle through the single read port of the table memory (at
//   most 16 entries in use). A request follows the search with the address
//   sum, the slot shift on a partial hole fit and the placement; a listing
//   reads one entry at a time and waits on each result. One item at a time.
//   A single result waits in a holding register until the output register
//   frees, so the next item can start while the receiver stalls; a listing
//   holds its walk until each line is taken. Reset empties the table and sets
//   total_size to its maximum; no clearing pass is needed since only entries
//   below the count are read.
module best_fit_partition_allocator_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  bfpa_pkg::in_item_t        in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output bfpa_pkg::out_item_t       out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bfpa_pkg::SizeBits-1:0] cfg_data
);
    import bfpa_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1; // best-fit search / release / compact read
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_SHIFT  = 4'd3; // move entries up one slot
    localparam logic [3:0] S_PLACE  = 4'd4;
    localparam logic [3:0] S_FIXUP  = 4'd5; // never entered; S_SHIFT shrinks the hole after the new entry
    localparam logic [3:0] S_LIST   = 4'd6;
    localparam logic [3:0] S_OUT    = 4'd7;
    localparam logic [3:0] S_ADDR   = 4'd8; // sum sizes below best

    logic [3:0]          state_reg, state_next;
    in_item_t            item_reg, item_next;
    logic [SizeBits-1:0] total_reg, total_next;
    logic [SizeBits-1:0] tail_reg, tail_next;
    logic [CntBits-1:0]  count_reg, count_next;
    logic [CntBits-1:0]  idx_reg, idx_next;   // read pointer
    logic [CntBits-1:0]  wj_reg, wj_next;     // compact write pointer
    logic                rvalid_reg, rvalid_next;
    logic [CntBits-1:0]  ridx_reg, ridx_next; // index of data now in rdata
    logic                found_reg, found_next;
    logic [IdxBits-1:0]  best_reg, best_next;
    logic [SizeBits-1:0] bsize_reg, bsize_next;
    logic [SizeBits-1:0] acc_reg, acc_next;   // running address
    logic                ovalid_reg, ovalid_next;
    out_item_t           odata_reg, odata_next;
    out_item_t           res_reg, res_next;   // single result waiting for the output

    logic                we;
    logic [IdxBits-1:0]  waddr, raddr;
    entry_t              wdata, rdata;

    bfpa_table u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !ovalid_reg && !in_valid;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    logic out_free;
    logic scan_last;
    assign out_free = !ovalid_reg || !out_stall;
    assign scan_last = rvalid_reg && (ridx_reg == count_reg - CntBits'(1));

    function automatic out_item_t mk(input logic [2:0] st, input logic [SizeBits-1:0] s,
                                     input logic [SizeBits-1:0] e, input logic [7:0] o,
                                     input logic f, input logic l);
        out_item_t r;
        r.status = st; r.start_addr = s; r.end_addr = e;
        r.owner = o; r.is_free = f; r.last = l;
        return r;
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        total_next  = total_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        wj_next     = wj_reg;
        rvalid_next = 1'b0;
        ridx_next   = idx_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        bsize_next  = bsize_reg;
        acc_next    = acc_reg;
        ovalid_next = ovalid_reg && out_stall;
        odata_next  = odata_reg;
        res_next    = res_reg;
        we          = 1'b0;
        waddr       = ridx_reg[IdxBits-1:0];
        wdata       = rdata;
        raddr       = idx_reg[IdxBits-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                begin
                    total_next = cfg_data;
                    tail_next  = cfg_data;
                    count_next = '0;
                end
                else if (in_valid)
                begin
                    item_next  = in_data;
                    idx_next   = '0;
                    wj_next    = '0;
                    found_next = 1'b0;
                    acc_next   = '0;
                    if (in_data.req_type == REQ_ALLOC && in_data.req_size == '0)
                    begin
                        state_next = S_OUT;
                        res_next   = mk(ST_BAD_SIZE, '0, '0, '0, 1'b0, 1'b1);
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = (in_data.req_type == REQ_LIST) ? S_LIST : S_DECIDE;
                    end
                    else
                    begin
                        state_next = (in_data.req_type == REQ_LIST) ? S_LIST : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // issue reads one per cycle, process the entry read last cycle
                if (idx_reg < count_reg)
                begin
                    rvalid_next = 1'b1;
                    idx_next    = idx_reg + CntBits'(1);
                end
                if (rvalid_reg)
                begin
                    unique case (item_reg.req_type)
                        REQ_ALLOC:
                        begin
                            if (rdata.free && rdata.size >= item_reg.req_size &&
                                (!found_reg || rdata.size < bsize_reg))
                            begin
                                found_next = 1'b1;
                                best_next  = ridx_reg[IdxBits-1:0];
                                bsize_next = rdata.size;
                            end
                        end
                        REQ_RELEASE:
                        begin
                            if (!rdata.free && rdata.owner == item_reg.proc_id)
                            begin
                                we          = 1'b1;
                                wdata.free  = 1'b1;
                                wdata.owner = '0;
                                found_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (rdata.free)
                            begin
                                tail_next = tail_reg + rdata.size;
                            end
                            else
                            begin
                                we      = 1'b1;
                                waddr   = wj_reg[IdxBits-1:0];
                                wj_next = wj_reg + CntBits'(1);
                            end
                        end
                    endcase
                    if (scan_last)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                state_next = S_OUT;
                unique case (item_reg.req_type)
                    REQ_ALLOC:
                    begin
                        if (found_next)
                        begin
                            if (bsize_reg != item_reg.req_size &&
                                count_reg >= CntBits'(MaxEntries))
                            begin
                                res_next = mk(ST_FULL, '0, '0, '0, 1'b0, 1'b1);
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_ADDR;
                            end
                        end
                        else if (item_reg.req_size > tail_reg)
                        begin
                            res_next = mk(ST_NO_SPACE, '0, '0, '0, 1'b0, 1'b1);
                        end
                        else if (count_reg >= CntBits'(MaxEntries))
                        begin
                            res_next = mk(ST_FULL, '0, '0, '0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            best_next  = count_reg[IdxBits-1:0];
                            idx_next   = '0;
                            state_next = S_ADDR;
                        end
                    end
                    REQ_RELEASE:
                    begin
                        res_next = mk(found_reg ? ST_OK : ST_NOT_FOUND,
                                      '0, '0, '0, 1'b0, 1'b1);
                    end
                    REQ_COMPACT:
                    begin
                        count_next = wj_reg;
                        res_next   = mk(ST_OK, '0, '0, '0, 1'b0, 1'b1);
                    end
                    default:
                    begin
                        res_next = mk(ST_OK, '0, '0, '0, 1'b0, 1'b1);
                    end
                endcase
            end
            S_ADDR:
            begin
                // accumulate sizes of entries below best, one per cycle
                if (idx_reg < {1'b0, best_reg})
                begin
                    rvalid_next = 1'b1;
                    idx_next    = idx_reg + CntBits'(1);
                end
                if (rvalid_reg)
                begin
                    acc_next = acc_reg + rdata.size;
                end
                if (!rvalid_reg && !(idx_reg < {1'b0, best_reg}))
                begin
                    if (found_reg && bsize_reg == item_reg.req_size)
                    begin
                        state_next = S_PLACE;
                    end
                    else if (found_reg)
                    begin
                        idx_next   = count_reg - CntBits'(1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        tail_next  = tail_reg - item_reg.req_size;
                        state_next = S_PLACE;
                    end
                end
            end
            S_SHIFT:
            begin
                // read entry idx, write it to ridx+1 next cycle; walk downward
                if (!rvalid_reg || ridx_reg > {1'b0, best_reg})
                begin
                    if (idx_reg >= {1'b0, best_reg} && !(rvalid_reg && ridx_reg ==
                        {1'b0, best_reg}))
                    begin
                        rvalid_next = 1'b1;
                        idx_next    = idx_reg - CntBits'(1);
                    end
                end
                if (rvalid_reg)
                begin
                    we    = 1'b1;
                    waddr = IdxBits'(ridx_reg + CntBits'(1));
                    if (ridx_reg == {1'b0, best_reg})
                    begin
                        wdata.size  = rdata.size - item_reg.req_size;
                        rvalid_next = 1'b0;
                        count_next  = count_reg + CntBits'(1);
                        state_next  = S_PLACE;
                    end
                end
            end
            S_PLACE:
            begin
                we          = 1'b1;
                waddr       = best_reg;
                wdata.free  = 1'b0;
                wdata.owner = item_reg.proc_id;
                wdata.size  = item_reg.req_size;
                if (!found_reg)
                begin
                    count_next = count_reg + CntBits'(1);
                end
                res_next   = mk(ST_OK, acc_reg, acc_reg + item_reg.req_size,
                                item_reg.proc_id, 1'b0, 1'b1);
                state_next = S_OUT;
            end
            S_LIST:
            begin
                // one read in flight at most; emit when output register frees
                if (!rvalid_reg && idx_reg < count_reg && !ovalid_next)
                begin
                    rvalid_next = 1'b1;
                    idx_next    = idx_reg + CntBits'(1);
                end
                else if (rvalid_reg)
                begin
                    if (out_free)
                    begin
                        ovalid_next = 1'b1;
                        odata_next  = mk(ST_OK, acc_reg, acc_reg + rdata.size,
                                         rdata.free ? 8'd0 : rdata.owner,
                                         rdata.free, 1'b0);
                        acc_next    = acc_reg + rdata.size;
                    end
                    else
                    begin
                        rvalid_next = 1'b1;
                        ridx_next   = ridx_reg;
                    end
                end
                else if (!rvalid_reg && idx_reg >= count_reg && out_free)
                begin
                    res_next   = mk(ST_OK, acc_reg, total_reg, '0, 1'b1, 1'b1);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // move the waiting result into the output register
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = res_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_LIST && rvalid_reg && !out_free)
        begin
            raddr = ridx_reg[IdxBits-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            total_reg  <= '1;
            tail_reg   <= '1;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        idx_reg   <= idx_next;
        wj_reg    <= wj_next;
        ridx_reg  <= ridx_next;
        found_reg <= found_next;
        best_reg  <= best_next;
        bsize_reg <= bsize_next;
        acc_reg   <= acc_next;
        odata_reg <= odata_next;
        res_reg   <= res_next;
    end
endmodule

@@ src/bfpa_checker.sv @@
// Port-level checker for the allocator core, bound to the top level.
// Depends on bfpa_pkg.
`timescale 1ns / 1ps
module bfpa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input bfpa_pkg::out_item_t out_data,
    input logic                cfg_ready
);
    import bfpa_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    // a taken input always makes the block busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block not busy after accept");
    // no config while working
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !cfg_ready)
        else $error("config ready while busy");
    // a hole or the tail line never carries an owner
    a_own: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_free |-> out_data.owner == 8'd0)
        else $error("free entry with owner");
endmodule

bind best_fit_partition_allocator_core bfpa_checker u_bfpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_ready (cfg_ready)
);
